/* rtl/rfc_pkg.sv */
package rfc_pkg;

  localparam int IDX_W = 6;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  localparam logic [7:0] START_MARKER_RESET = 8'hBB;
  localparam logic [7:0] END_MARKER_RESET   = 8'h7E;

  localparam logic [7:0] CMD_ERROR_FLAG = 8'hFF;
  localparam logic [7:0] STATUS_COMMAND = 8'h17;
  localparam logic [7:0] STATUS_POLLING = 8'h15;

  // Frame positions whose bytes are captured; POS_SUM_GO marks where checksum summing begins.
  localparam logic [IDX_W-1:0] POS_START   = 6'd0;
  localparam logic [IDX_W-1:0] POS_TYPE    = 6'd1;
  localparam logic [IDX_W-1:0] POS_COMMAND = 6'd2;
  localparam logic [IDX_W-1:0] POS_STATUS  = 6'd5;
  localparam logic [IDX_W-1:0] POS_SUM_GO  = 6'd2;

  typedef enum logic [2:0] {
    VERDICT_OK         = 3'd0,
    VERDICT_NOT_PACKET = 3'd1,
    VERDICT_CHECKSUM   = 3'd2,
    VERDICT_COMMAND    = 3'd3,
    VERDICT_POLLING    = 3'd4,
    VERDICT_OTHER      = 3'd5
  } verdict_t;

  typedef enum logic {
    CFG_START_MARKER = 1'b0,
    CFG_END_MARKER   = 1'b1
  } cfg_index_t;

endpackage

/* rtl/reader_frame_checker.sv */
// A frame's last byte is accepted into the input register, and its verdict is then
// loaded from there into the result register, which drives the result port.
// Throughput: one byte per cycle; a last byte waits in the input register only while
// an earlier verdict has not been taken, since the result register holds one request.
// Reset (rst_n low, synchronous): frame state and loss counter clear, markers return
// to 0xBB and 0x7E, both channels go empty.
module reader_frame_checker #(
  parameter int FRAME_LIMIT = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_frame_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_verdict,
  output logic [7:0] out_frame_type,
  output logic [7:0] out_command_code,
  output logic [15:0] out_loss_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int IW = rfc_pkg::IDX_W;
  localparam logic [IW-1:0] LIMIT_M1 = IW'(FRAME_LIMIT - 1);

  logic [7:0] start_marker_r, end_marker_r;

  logic          a_valid_r;
  logic [7:0]    a_byte_r;
  logic          a_last_r;

  logic [IW-1:0] idx_r, idx_nxt;
  logic          start_r, start_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [7:0]    stat_r, stat_nxt;
  logic [15:0]   loss_r, loss_nxt;

  logic          out_valid_r;
  rfc_pkg::verdict_t verdict_r, verdict_nxt;
  logic [7:0]    out_type_r, out_cmd_r;

  logic out_free, advance, load_out;
  logic start_cap;
  logic [7:0] type_cap, cmd_cap, stat_cap;
  logic bad_frame;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= rfc_pkg::START_MARKER_RESET;
      end_marker_r   <= rfc_pkg::END_MARKER_RESET;
    end else if (cfg_valid) begin
      case (rfc_pkg::cfg_index_t'(cfg_index))
        rfc_pkg::CFG_START_MARKER: start_marker_r <= cfg_data;
        rfc_pkg::CFG_END_MARKER:   end_marker_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Only a last byte needs the result register; other bytes always move on.
  assign out_free = !out_valid_r || out_ready;
  assign advance  = a_valid_r && (!a_last_r || out_free);
  assign load_out = advance && a_last_r;
  assign in_ready = !a_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_byte_r <= in_rx_byte;
      a_last_r <= in_frame_last;
    end
  end

  // The current byte is captured first, so a last byte at a captured position is seen.
  always_comb begin
    start_cap = (idx_r == rfc_pkg::POS_START) ? (a_byte_r == start_marker_r) : start_r;
    type_cap  = (idx_r == rfc_pkg::POS_TYPE)    ? a_byte_r : type_r;
    cmd_cap   = (idx_r == rfc_pkg::POS_COMMAND) ? a_byte_r : cmd_r;
    stat_cap  = (idx_r == rfc_pkg::POS_STATUS)  ? a_byte_r : stat_r;
  end

  always_comb begin
    bad_frame = (idx_r < rfc_pkg::POS_SUM_GO) || (idx_r >= LIMIT_M1) || !start_cap ||
                (a_byte_r != end_marker_r);
    if (bad_frame) begin
      verdict_nxt = rfc_pkg::VERDICT_NOT_PACKET;
    end else if (sum_r != prev_r) begin
      verdict_nxt = rfc_pkg::VERDICT_CHECKSUM;
    end else if (cmd_cap != rfc_pkg::CMD_ERROR_FLAG) begin
      verdict_nxt = rfc_pkg::VERDICT_OK;
    end else if (stat_cap == rfc_pkg::STATUS_COMMAND) begin
      verdict_nxt = rfc_pkg::VERDICT_COMMAND;
    end else if (stat_cap == rfc_pkg::STATUS_POLLING) begin
      verdict_nxt = rfc_pkg::VERDICT_POLLING;
    end else begin
      verdict_nxt = rfc_pkg::VERDICT_OTHER;
    end
  end

  always_comb begin
    idx_nxt   = idx_r;
    start_nxt = start_r;
    sum_nxt   = sum_r;
    prev_nxt  = prev_r;
    type_nxt  = type_r;
    cmd_nxt   = cmd_r;
    stat_nxt  = stat_r;
    loss_nxt  = loss_r;
    if (advance) begin
      if (a_last_r) begin
        idx_nxt   = '0;
        start_nxt = 1'b0;
        sum_nxt   = '0;
        prev_nxt  = '0;
        type_nxt  = '0;
        cmd_nxt   = '0;
        stat_nxt  = '0;
        if (verdict_nxt != rfc_pkg::VERDICT_OK) begin
          loss_nxt = loss_r + 16'd1;
        end
      end else begin
        start_nxt = start_cap;
        type_nxt  = type_cap;
        cmd_nxt   = cmd_cap;
        stat_nxt  = stat_cap;
        if (idx_r >= rfc_pkg::POS_SUM_GO) begin
          sum_nxt = sum_r + prev_r;
        end
        prev_nxt = a_byte_r;
        if (idx_r != rfc_pkg::IDX_MAX) begin
          idx_nxt = idx_r + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      start_r <= 1'b0;
      sum_r   <= '0;
      prev_r  <= '0;
      type_r  <= '0;
      cmd_r   <= '0;
      stat_r  <= '0;
      loss_r  <= '0;
    end else begin
      idx_r   <= idx_nxt;
      start_r <= start_nxt;
      sum_r   <= sum_nxt;
      prev_r  <= prev_nxt;
      type_r  <= type_nxt;
      cmd_r   <= cmd_nxt;
      stat_r  <= stat_nxt;
      loss_r  <= loss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= load_out;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      verdict_r  <= verdict_nxt;
      out_type_r <= type_cap;
      out_cmd_r  <= cmd_cap;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = verdict_r;
  assign out_frame_type   = out_type_r;
  assign out_command_code = out_cmd_r;
  assign out_loss_count   = loss_r;

  // The loss counter moves only when a verdict is loaded.
  a_loss_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    !load_out |=> $stable(loss_r))
    else $error("loss counter changed without a verdict");

  // A good frame leaves the loss counter alone.
  a_ok_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && (verdict_nxt == rfc_pkg::VERDICT_OK) |=> loss_r == $past(loss_r))
    else $error("good frame counted as lost");

  // Frame state is cleared after every last byte.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (idx_r == '0) && !start_r && (sum_r == '0) && (prev_r == '0))
    else $error("frame state not cleared after last byte");

  // A pending verdict is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !load_out)
    else $error("verdict loaded while previous request still waits");

endmodule

/* sim/reader_frame_checker_tb.sv */
module reader_frame_checker_tb;

  localparam int FRAME_LIMIT = 32;
  localparam int DIR_N = 29;
  localparam int PHASE_BYTES = 170;
  localparam int SHOW_MAX = 40;

  typedef struct packed {
    rfc_pkg::verdict_t verdict;
    logic [7:0]  frame_type;
    logic [7:0]  command_code;
    logic [15:0] loss_count;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        last;
    logic        typed;
    rfc_pkg::verdict_t v;
    logic [7:0]  ft;
    logic [7:0]  cc;
    logic [15:0] lc;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        in_frame_last;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_verdict;
  logic [7:0]  out_frame_type;
  logic [7:0]  out_command_code;
  logic [15:0] out_loss_count;
  logic        cfg_valid;
  logic        cfg_ready;
  rfc_pkg::cfg_index_t cfg_index;
  logic [7:0]  cfg_data;

  // Predictor state.
  logic [7:0]  start_mark;
  logic [7:0]  end_mark;
  logic [5:0]  byte_pos;
  logic        start_ok;
  logic [7:0]  sum_acc;
  logic [7:0]  prev_b;
  logic [7:0]  type_b;
  logic [7:0]  cmd_b;
  logic [7:0]  status_b;
  logic [15:0] lost;

  frame_result_t verdicts_due [$];
  stim_row_t     dir_rows [DIR_N];

  int send_idle;
  int recv_idle;
  int mismatches;
  int bytes_sent;
  int frames_sent;
  int verdicts_checked;
  int marker_writes;
  int verdict_seen [6];

  reader_frame_checker #(.FRAME_LIMIT(FRAME_LIMIT)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_frame_last    (in_frame_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_verdict      (out_verdict),
    .out_frame_type   (out_frame_type),
    .out_command_code (out_command_code),
    .out_loss_count   (out_loss_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < SHOW_MAX)
      $display("mismatch: %s got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  function automatic void clear_frame_state();
    byte_pos = '0;
    start_ok = 1'b0;
    sum_acc  = '0;
    prev_b   = '0;
    type_b   = '0;
    cmd_b    = '0;
    status_b = '0;
  endfunction

  function automatic void frame_step(input logic [7:0] b, input logic last,
                                     output bit has_res, output frame_result_t r);
    logic [5:0]  k;
    int unsigned n;
    rfc_pkg::verdict_t v;
    k = byte_pos;
    has_res = 1'b0;
    r = '0;
    case (k)
      rfc_pkg::POS_START:   start_ok = (b == start_mark);
      rfc_pkg::POS_TYPE:    type_b = b;
      rfc_pkg::POS_COMMAND: cmd_b = b;
      rfc_pkg::POS_STATUS:  status_b = b;
      default: ;
    endcase
    if (!last) begin
      if (k >= rfc_pkg::POS_SUM_GO) sum_acc = sum_acc + prev_b;
      prev_b = b;
      if (k != rfc_pkg::IDX_MAX) byte_pos = k + 6'd1;
    end else begin
      n = k + 1;
      if (n < 3 || k == rfc_pkg::IDX_MAX || !start_ok || b != end_mark ||
          n >= FRAME_LIMIT)
        v = rfc_pkg::VERDICT_NOT_PACKET;
      else if (sum_acc != prev_b)
        v = rfc_pkg::VERDICT_CHECKSUM;
      else if (cmd_b != rfc_pkg::CMD_ERROR_FLAG)
        v = rfc_pkg::VERDICT_OK;
      else if (status_b == rfc_pkg::STATUS_COMMAND)
        v = rfc_pkg::VERDICT_COMMAND;
      else if (status_b == rfc_pkg::STATUS_POLLING)
        v = rfc_pkg::VERDICT_POLLING;
      else
        v = rfc_pkg::VERDICT_OTHER;
      if (v != rfc_pkg::VERDICT_OK) lost = lost + 16'd1;
      r.verdict      = v;
      r.frame_type   = type_b;
      r.command_code = cmd_b;
      r.loss_count   = lost;
      has_res = 1'b1;
      clear_frame_state();
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken,
  // with valid still high so the next byte can follow without a gap.
  task automatic send_byte(input logic [7:0] b, input logic last,
                           output bit has_res, output frame_result_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_rx_byte    = b;
    in_frame_last = last;
    do @(posedge clk); while (!in_ready);
    frame_step(b, last, has_res, r);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_frame();
    logic [7:0]    fb [$];
    int unsigned   n;
    int unsigned   roll;
    int unsigned   i;
    logic [7:0]    sum;
    bit            has_res;
    frame_result_t r;
    roll = $urandom_range(99);
    if (roll < 16) begin
      // Short frames and plain noise.
      n = (roll < 8) ? $urandom_range(2, 1) : $urandom_range(10, 1);
      for (i = 0; i < n; i++) fb.push_back(8'($urandom_range(255)));
      if ($urandom_range(1)) fb[0] = start_mark;
      if ($urandom_range(1)) fb[n-1] = end_mark;
    end else begin
      if (roll < 22)
        n = $urandom_range(1) ? $urandom_range(FRAME_LIMIT + 1, FRAME_LIMIT)
                              : $urandom_range(70, 60);
      else if ($urandom_range(3) == 0)
        n = $urandom_range(FRAME_LIMIT - 1, 3);
      else
        n = $urandom_range(12, 3);
      fb.push_back(start_mark);
      for (i = 1; i + 2 < n; i++) fb.push_back(8'($urandom_range(255)));
      if (n >= 5 && $urandom_range(2) == 0) begin
        fb[2] = rfc_pkg::CMD_ERROR_FLAG;
        if (n >= 8) begin
          case ($urandom_range(2))
            0: fb[5] = rfc_pkg::STATUS_COMMAND;
            1: fb[5] = rfc_pkg::STATUS_POLLING;
            default: fb[5] = 8'($urandom_range(255));
          endcase
        end
      end
      sum = '0;
      for (i = 1; i + 2 < n; i++) sum = sum + fb[i];
      fb.push_back(sum);
      fb.push_back(end_mark);
      if (roll >= 22 && roll < 30) fb[n-2] = fb[n-2] ^ 8'($urandom_range(255, 1));
      else if (roll >= 30 && roll < 38) fb[0] = fb[0] ^ 8'($urandom_range(255, 1));
      else if (roll >= 38 && roll < 46) fb[n-1] = fb[n-1] ^ 8'($urandom_range(255, 1));
    end
    for (i = 0; i < fb.size(); i++) begin
      send_byte(fb[i], i == fb.size() - 1, has_res, r);
      if (has_res) verdicts_due.push_back(r);
    end
    frames_sent++;
  endtask

  // Stop sending, then wait for every pending verdict, with some slack after it.
  task automatic drain();
    in_valid = 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_markers(input logic [7:0] s, input logic [7:0] e);
    cfg_valid = 1'b1;
    cfg_index = rfc_pkg::CFG_START_MARKER;
    cfg_data  = s;
    do @(posedge clk); while (!cfg_ready);
    start_mark = s;
    @(negedge clk);
    cfg_index = rfc_pkg::CFG_END_MARKER;
    cfg_data  = e;
    do @(posedge clk); while (!cfg_ready);
    end_mark = e;
    @(negedge clk);
    cfg_valid = 1'b0;
    marker_writes++;
  endtask

  task automatic next_markers();
    case (marker_writes)
      0: write_markers(8'h00, 8'hFF);
      1: write_markers(8'hFF, 8'h00);
      2: write_markers(8'hFF, 8'hFF);
      3: write_markers(8'($urandom_range(255)), 8'($urandom_range(255)));
      4: write_markers(8'h00, 8'h00);
      5: write_markers(8'($urandom_range(255)), 8'($urandom_range(255)));
      default: write_markers(rfc_pkg::START_MARKER_RESET, rfc_pkg::END_MARKER_RESET);
    endcase
  endtask

  always @(negedge clk) out_ready = ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("verdict with none pending", int'(out_verdict), 0);
      end else begin
        want = verdicts_due.pop_front();
        verdicts_checked++;
        verdict_seen[int'(want.verdict)]++;
        if (out_verdict !== want.verdict)
          report_mismatch("verdict", int'(out_verdict), int'(want.verdict));
        if (out_frame_type !== want.frame_type)
          report_mismatch("frame_type", int'(out_frame_type), int'(want.frame_type));
        if (out_command_code !== want.command_code)
          report_mismatch("command_code", int'(out_command_code), int'(want.command_code));
        if (out_loss_count !== want.loss_count)
          report_mismatch("loss_count", int'(out_loss_count), int'(want.loss_count));
      end
    end
  end

  initial begin
    #200000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int            ph;
    int            i;
    int            target;
    bit            wrote_mid;
    bit            has_res;
    frame_result_t r;
    frame_result_t typed_res;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_rx_byte    = '0;
    in_frame_last = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = rfc_pkg::CFG_START_MARKER;
    cfg_data      = '0;
    send_idle     = 34;
    recv_idle     = 52;
    mismatches    = 0;
    bytes_sent    = 0;
    frames_sent   = 0;
    verdicts_checked = 0;
    marker_writes = 0;
    for (i = 0; i < 6; i++) verdict_seen[i] = 0;
    start_mark = rfc_pkg::START_MARKER_RESET;
    end_mark   = rfc_pkg::END_MARKER_RESET;
    lost       = '0;
    clear_frame_state();

    dir_rows = '{
      '{8'hBB, 1'b1, 1'b1, rfc_pkg::VERDICT_NOT_PACKET, 8'h00, 8'h00, 16'd1},
      '{8'hBB, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h7E, 1'b1, 1'b1, rfc_pkg::VERDICT_NOT_PACKET, 8'h7E, 8'h00, 16'd2},
      '{8'hBB, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h00, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h7E, 1'b1, 1'b1, rfc_pkg::VERDICT_OK,         8'h00, 8'h7E, 16'd2},
      '{8'hBB, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h05, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h7E, 1'b1, 1'b1, rfc_pkg::VERDICT_CHECKSUM,   8'h05, 8'h7E, 16'd3},
      '{8'hBB, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h01, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'hFF, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h00, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h00, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h17, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h17, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h7E, 1'b1, 1'b1, rfc_pkg::VERDICT_COMMAND,    8'h01, 8'hFF, 16'd4},
      '{8'hBB, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h02, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'hFF, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h14, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h00, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h15, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h7E, 1'b1, 1'b1, rfc_pkg::VERDICT_POLLING,    8'h02, 8'hFF, 16'd5},
      '{8'hBB, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h01, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'hFF, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h00, 1'b0, 1'b0, rfc_pkg::VERDICT_OK,         8'h00, 8'h00, 16'd0},
      '{8'h7E, 1'b1, 1'b1, rfc_pkg::VERDICT_OTHER,      8'h01, 8'hFF, 16'd6}
    };

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed frames run with the reset markers.
    for (i = 0; i < DIR_N; i++) begin
      send_byte(dir_rows[i].b, dir_rows[i].last, has_res, r);
      if (has_res) begin
        if (dir_rows[i].typed) begin
          typed_res.verdict      = dir_rows[i].v;
          typed_res.frame_type   = dir_rows[i].ft;
          typed_res.command_code = dir_rows[i].cc;
          typed_res.loss_count   = dir_rows[i].lc;
          verdicts_due.push_back(typed_res);
        end else begin
          verdicts_due.push_back(r);
        end
      end
    end
    frames_sent += 7;
    drain();
    next_markers();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle = 34; recv_idle = 52; end
        1: begin send_idle = 52; recv_idle = 34; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      target = bytes_sent + PHASE_BYTES;
      wrote_mid = 1'b0;
      while (bytes_sent < target) begin
        if (!wrote_mid && bytes_sent >= target - PHASE_BYTES / 2) begin
          drain();
          next_markers();
          wrote_mid = 1'b1;
        end
        send_random_frame();
      end
      drain();
      next_markers();
    end

    repeat (8) @(negedge clk);

    $display("%0d bytes in %0d frames, %0d verdicts compared, %0d marker settings",
             bytes_sent, frames_sent, verdicts_checked, marker_writes);
    $display("verdicts ok %0d, not a packet %0d, checksum %0d, command %0d, polling %0d, other %0d",
             verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
             verdict_seen[4], verdict_seen[5]);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
